// ===== rtl/ihexw_pkg.sv =====
package ihexw_pkg;

  // Fixed character codes and record types of the hex text format.
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNone   = 8'h00;
  localparam logic [7:0] TypeData = 8'h00;
  localparam logic [7:0] TypeEof  = 8'h01;

  // One input word.
  typedef struct packed {
    logic        cmd;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } ihexw_in_t;

  // One output word.
  typedef struct packed {
    logic [7:0] out_char;
    logic       error;
    logic       last;
  } ihexw_out_t;

  // One job for the character sequencer: an error mark, or a data record
  // to flush, an end-of-file record, or both in that order.
  typedef struct packed {
    logic        is_err;
    logic        has_rec;
    logic        rec_bank;
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_csum;
    logic        has_eof;
    logic [15:0] eof_addr;
    logic [7:0]  eof_csum;
  } ihexw_job_t;

  // Release of a buffer bank once its data bytes have been read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } ihexw_done_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/ihexw_ram.sv =====
module ihexw_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
  )
  (
    input  logic                     clk_i,
    input  logic                     we_i,
    input  logic [$clog2(DEPTH)-1:0] waddr_i,
    input  logic [WIDTH-1:0]         wdata_i,
    input  logic [$clog2(DEPTH)-1:0] raddr_i,
    output logic [WIDTH-1:0]         rdata_o
  );

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ihexw_front.sv =====
module ihexw_front
  import ihexw_pkg::*;
  #(
    parameter int MAX_RECORD_BYTES = 16,
    parameter int MEMORY_SIZE      = 256,
    parameter int CNTW             = 5,
    parameter int AW               = 5
  )
  (
    input  logic        clk_i,
    input  logic        rst_ni,
    input  logic        in_valid_i,
    output logic        in_stall_o,
    input  ihexw_in_t   in_word_i,
    input  logic        q_full_i,
    output logic        q_push_o,
    output ihexw_job_t  q_job_o,
    input  ihexw_done_t done_i,
    output logic        ram_we_o,
    output logic [AW-1:0] ram_waddr_o,
    output logic [7:0]  ram_wdata_o
  );

  localparam logic [16:0]     MemSizeW = 17'(MEMORY_SIZE);
  localparam logic [CNTW-1:0] MaxCount = CNTW'(MAX_RECORD_BYTES);
  localparam logic [AW-1:0]   BankOffs = AW'(MAX_RECORD_BYTES);

  logic            hold_valid_q, hold_valid_d;
  ihexw_in_t       hold_q, hold_d;
  logic            cur_bank_q, cur_bank_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [15:0]     rec_addr_q, rec_addr_d;
  logic [16:0]     exp_addr_q, exp_addr_d;
  logic            exp_valid_q, exp_valid_d;
  logic [7:0]      sum_q, sum_d;
  logic [1:0]      busy_q, busy_d;

  logic            is_fin, in_range, follows, start_new, flush, need_job;
  logic            new_bank, bank_ok, fire, wr_bank;
  logic [CNTW-1:0] wr_idx;

  // Classification of the held word.
  always_comb begin
    is_fin    = hold_q.cmd;
    in_range  = {1'b0, hold_q.address} < MemSizeW;
    follows   = exp_valid_q && (exp_addr_q == {1'b0, hold_q.address});
    start_new = !is_fin && in_range &&
                (!follows || (count_q == '0) || (count_q == MaxCount));
    flush     = (is_fin || start_new) && (count_q != '0);
    need_job  = is_fin || !in_range || flush;
    new_bank  = flush ? ~cur_bank_q : cur_bank_q;
    bank_ok   = !(start_new && busy_q[new_bank]);
    fire      = hold_valid_q && (!need_job || !q_full_i) && bank_ok;
  end

  assign in_stall_o = hold_valid_q && !fire;

  // Job handed to the character sequencer.
  always_comb begin
    q_push_o          = fire && need_job;
    q_job_o.is_err    = !is_fin && !in_range;
    q_job_o.has_rec   = flush;
    q_job_o.rec_bank  = cur_bank_q;
    q_job_o.rec_count = 8'(count_q);
    q_job_o.rec_addr  = rec_addr_q;
    q_job_o.rec_csum  = 8'(8'h00 - (sum_q + 8'(count_q) + TypeData));
    q_job_o.has_eof   = is_fin;
    q_job_o.eof_addr  = hold_q.address;
    q_job_o.eof_csum  = 8'(8'h00 - (hold_q.address[15:8] + hold_q.address[7:0] + TypeEof));
  end

  // Buffer write: a new record starts at index zero of its bank.
  always_comb begin
    wr_bank     = start_new ? new_bank : cur_bank_q;
    wr_idx      = start_new ? '0 : count_q;
    ram_we_o    = fire && !is_fin && in_range;
    ram_waddr_o = wr_bank ? (BankOffs + AW'(wr_idx)) : AW'(wr_idx);
    ram_wdata_o = hold_q.data_byte;
  end

  // Record state update.
  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    cur_bank_d   = cur_bank_q;
    count_d      = count_q;
    rec_addr_d   = rec_addr_q;
    exp_addr_d   = exp_addr_q;
    exp_valid_d  = exp_valid_q;
    sum_d        = sum_q;
    busy_d       = busy_q;

    if (fire) begin
      hold_valid_d = 1'b0;
      if (is_fin) begin
        if (flush) begin
          count_d    = '0;
          cur_bank_d = ~cur_bank_q;
        end
      end else begin
        exp_addr_d  = 17'(hold_q.address) + 17'd1;
        exp_valid_d = 1'b1;
        if (in_range) begin
          if (start_new) begin
            cur_bank_d = new_bank;
            rec_addr_d = hold_q.address;
            count_d    = CNTW'(1);
            sum_d      = 8'(hold_q.address[15:8] + hold_q.address[7:0] + hold_q.data_byte);
          end else begin
            count_d = count_q + CNTW'(1);
            sum_d   = 8'(sum_q + hold_q.data_byte);
          end
        end
      end
    end

    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (fire && flush) begin
      busy_d[cur_bank_q] = 1'b1;
    end

    if (in_valid_i && !in_stall_o) begin
      hold_valid_d = 1'b1;
      hold_d       = in_word_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cur_bank_q   <= 1'b0;
      count_q      <= '0;
      rec_addr_q   <= '0;
      exp_addr_q   <= '0;
      exp_valid_q  <= 1'b0;
      sum_q        <= '0;
      busy_q       <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      cur_bank_q   <= cur_bank_d;
      count_q      <= count_d;
      rec_addr_q   <= rec_addr_d;
      exp_addr_q   <= exp_addr_d;
      exp_valid_q  <= exp_valid_d;
      sum_q        <= sum_d;
      busy_q       <= busy_d;
    end
  end

  // Held word payload.
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // The pending record never grows past the record limit.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("pending record count above limit");

  // A byte is never written into a bank that is still being read out.
  a_no_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !busy_q[wr_bank])
    else $error("write into a bank still in use");

endmodule

// ===== rtl/ihexw_queue.sv =====
module ihexw_queue
  import ihexw_pkg::*;
  (
    input  logic       clk_i,
    input  logic       rst_ni,
    input  logic       push_i,
    input  ihexw_job_t job_i,
    output logic       full_o,
    input  logic       pop_i,
    output logic       empty_o,
    output ihexw_job_t job_o
  );

  ihexw_job_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // Neither side runs past the fill level.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("job queue overrun or underrun");

endmodule

// ===== rtl/ihexw_back.sv =====
module ihexw_back
  import ihexw_pkg::*;
  #(
    parameter int MAX_RECORD_BYTES = 16,
    parameter int CNTW             = 5,
    parameter int AW               = 5
  )
  (
    input  logic          clk_i,
    input  logic          rst_ni,
    input  logic          q_empty_i,
    input  ihexw_job_t    q_job_i,
    output logic          q_pop_o,
    output ihexw_done_t   done_o,
    output logic [AW-1:0] ram_raddr_o,
    input  logic [7:0]    ram_rdata_i,
    output logic          out_valid_o,
    input  logic          out_stall_i,
    output ihexw_out_t    out_word_o
  );

  localparam logic [AW-1:0] BankOffs = AW'(MAX_RECORD_BYTES);

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StErr   = 11'b000_0000_0010,
    StColon = 11'b000_0000_0100,
    StCnt   = 11'b000_0000_1000,
    StAdh   = 11'b000_0001_0000,
    StAdl   = 11'b000_0010_0000,
    StTyp   = 11'b000_0100_0000,
    StData  = 11'b000_1000_0000,
    StSum   = 11'b001_0000_0000,
    StCr    = 11'b010_0000_0000,
    StLf    = 11'b100_0000_0000
  } bk_state_e;

  bk_state_e       state_q, state_d;
  logic            nib_q, nib_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic            eof_q, eof_d;
  ihexw_job_t      job_q, job_d;
  logic            out_valid_q, out_valid_d;
  ihexw_out_t      out_word_q, out_word_d;

  logic            emit, byte_done, last_byte;
  logic [7:0]      byte_val;
  ihexw_out_t      cur_word;

  assign emit      = (state_q != StIdle) && (!out_valid_q || !out_stall_i);
  assign byte_done = emit && nib_q;
  assign last_byte = (8'(idx_q) + 8'd1) == job_q.rec_count;

  // Byte that the current field sends as two hex digits.
  always_comb begin
    unique case (state_q)
      StCnt:   byte_val = eof_q ? 8'h00 : job_q.rec_count;
      StAdh:   byte_val = eof_q ? job_q.eof_addr[15:8] : job_q.rec_addr[15:8];
      StAdl:   byte_val = eof_q ? job_q.eof_addr[7:0] : job_q.rec_addr[7:0];
      StTyp:   byte_val = eof_q ? TypeEof : TypeData;
      StData:  byte_val = ram_rdata_i;
      StSum:   byte_val = eof_q ? job_q.eof_csum : job_q.rec_csum;
      default: byte_val = 8'h00;
    endcase
  end

  // Character of the current step.
  always_comb begin
    unique case (state_q)
      StColon: cur_word.out_char = ChColon;
      StCr:    cur_word.out_char = ChCr;
      StLf:    cur_word.out_char = ChLf;
      StErr:   cur_word.out_char = ChNone;
      StIdle:  cur_word.out_char = ChNone;
      default: cur_word.out_char = hex_char(nib_q ? byte_val[3:0] : byte_val[7:4]);
    endcase
    cur_word.error = state_q == StErr;
    cur_word.last  = (state_q == StErr) ||
                     ((state_q == StLf) && (eof_q || !job_q.has_eof));
  end

  // Character sequencer.
  always_comb begin
    state_d = state_q;
    nib_d   = nib_q;
    idx_d   = idx_q;
    eof_d   = eof_q;
    job_d   = job_q;
    q_pop_o = 1'b0;
    done_o  = '{valid: 1'b0, bank: job_q.rec_bank};

    if (emit && (state_q != StColon) && (state_q != StCr) &&
        (state_q != StLf) && (state_q != StErr)) begin
      nib_d = ~nib_q;
    end

    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          idx_d   = '0;
          nib_d   = 1'b0;
          eof_d   = !q_job_i.has_rec;
          state_d = q_job_i.is_err ? StErr : StColon;
        end
      end
      StErr: begin
        if (emit) state_d = StIdle;
      end
      StColon: begin
        if (emit) state_d = StCnt;
      end
      StCnt: begin
        if (byte_done) state_d = StAdh;
      end
      StAdh: begin
        if (byte_done) state_d = StAdl;
      end
      StAdl: begin
        if (byte_done) state_d = StTyp;
      end
      StTyp: begin
        if (byte_done) begin
          idx_d   = '0;
          state_d = eof_q ? StSum : StData;
        end
      end
      StData: begin
        if (byte_done) begin
          if (last_byte) begin
            done_o.valid = 1'b1;
            state_d      = StSum;
          end else begin
            idx_d = idx_q + CNTW'(1);
          end
        end
      end
      StSum: begin
        if (byte_done) state_d = StCr;
      end
      StCr: begin
        if (emit) state_d = StLf;
      end
      StLf: begin
        if (emit) begin
          if (!eof_q && job_q.has_eof) begin
            eof_d   = 1'b1;
            state_d = StColon;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Read from the next index, so that through the registered RAM read the byte is there when its first digit goes out.
  assign ram_raddr_o = job_d.rec_bank ? (BankOffs + AW'(idx_d)) : AW'(idx_d);

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_word_d  = cur_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      nib_q       <= 1'b0;
      idx_q       <= '0;
      eof_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nib_q       <= nib_d;
      idx_q       <= idx_d;
      eof_q       <= eof_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Data bytes are only read inside the record's fill.
  a_idx_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StData) |-> (8'(idx_q) < job_q.rec_count))
    else $error("data index beyond record count");

  // A job taken while the sequencer is idle always starts the sequencer.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != StIdle))
    else $error("job taken without starting the sequencer");

endmodule

// ===== rtl/intel_hex_record_writer.sv =====
// A word is held in a register and classified; the records it closes go
// through the job queue and the sequencer into the output register.
// Appended bytes never stall the input; the sequencer takes each job while
// idle and sends one character per cycle unless the output stalls:
// 2 * count + 13 for a data record, 13 for end of file, 1 for an error word.
// Reset clears all control state; the record buffer RAM is not cleared.
module intel_hex_record_writer
  import ihexw_pkg::*;
  #(
    parameter int MAX_RECORD_BYTES = 16,
    parameter int MEMORY_SIZE      = 256
  )
  (
    input  logic       clk_i,
    input  logic       rst_ni,
    input  logic       in_valid_i,
    output logic       in_stall_o,
    input  ihexw_in_t  in_word_i,
    output logic       out_valid_o,
    input  logic       out_stall_i,
    output ihexw_out_t out_word_o
  );

  localparam int CNTW  = $clog2(MAX_RECORD_BYTES + 1);
  localparam int DEPTH = 2 * MAX_RECORD_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic          q_full, q_push, q_pop, q_empty;
  ihexw_job_t    q_job_in, q_job_out;
  ihexw_done_t   done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Two banks of the record buffer: one fills while the other is sent.
  ihexw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ihexw_front #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MEMORY_SIZE      (MEMORY_SIZE),
    .CNTW             (CNTW),
    .AW               (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in),
    .done_i      (done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  ihexw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_job_out)
  );

  ihexw_back #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .CNTW             (CNTW),
    .AW               (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .done_o      (done),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench
  import ihexw_pkg::*;
  ();

  localparam int MemBytes    = 256;
  localparam int RecBytes    = 16;
  localparam int RandomWords = 320;
  localparam int HoldCycles  = 400;
  localparam int WatchLimit  = 3000;
  localparam int DrainCycles = 40;
  localparam logic [127:0] HexDigits = "0123456789ABCDEF";
  localparam logic [87:0] NoText = '0;

  // How the expected text of a plan row is obtained.
  typedef enum logic [1:0] {
    ByModel,
    TypedText,
    TypedError
  } row_check_e;

  // One row of the directed plan; typed rows carry an 11-character record
  // without its line end.
  typedef struct packed {
    row_check_e  check;
    ihexw_in_t   word;
    logic [87:0] text;
  } plan_row_t;

  localparam plan_row_t Plan [26] = '{
    // End of file right after reset.
    '{TypedText,  '{1'b1, 16'h0000, 8'h00}, ":00000001FF"},
    '{ByModel,    '{1'b0, 16'h0000, 8'h00}, NoText},
    '{ByModel,    '{1'b0, 16'h0001, 8'hFF}, NoText},
    // First address beyond memory: dropped, error mark.
    '{TypedError, '{1'b0, 16'h0100, 8'h5A}, NoText},
    '{ByModel,    '{1'b0, 16'h0004, 8'hAA}, NoText},
    '{TypedError, '{1'b0, 16'hFFFF, 8'hFF}, NoText},
    // After 0xFFFF, address 0x0000 does not continue the record.
    '{ByModel,    '{1'b0, 16'h0000, 8'h80}, NoText},
    '{ByModel,    '{1'b0, 16'h0001, 8'h7F}, NoText},
    '{ByModel,    '{1'b0, 16'h0002, 8'h01}, NoText},
    '{ByModel,    '{1'b0, 16'h0003, 8'hFE}, NoText},
    '{ByModel,    '{1'b0, 16'h0004, 8'h5A}, NoText},
    '{ByModel,    '{1'b0, 16'h0005, 8'hA5}, NoText},
    '{ByModel,    '{1'b0, 16'h0006, 8'h3C}, NoText},
    '{ByModel,    '{1'b0, 16'h0007, 8'hC3}, NoText},
    '{ByModel,    '{1'b0, 16'h0008, 8'h12}, NoText},
    '{ByModel,    '{1'b0, 16'h0009, 8'h34}, NoText},
    '{ByModel,    '{1'b0, 16'h000A, 8'h56}, NoText},
    '{ByModel,    '{1'b0, 16'h000B, 8'h78}, NoText},
    '{ByModel,    '{1'b0, 16'h000C, 8'h9A}, NoText},
    '{ByModel,    '{1'b0, 16'h000D, 8'hBC}, NoText},
    '{ByModel,    '{1'b0, 16'h000E, 8'hDE}, NoText},
    '{ByModel,    '{1'b0, 16'h000F, 8'hF0}, NoText},
    // The seventeenth contiguous byte closes a full record.
    '{ByModel,    '{1'b0, 16'h0010, 8'h0F}, NoText},
    '{ByModel,    '{1'b1, 16'h0010, 8'hFF}, NoText},
    '{TypedText,  '{1'b1, 16'hFFFF, 8'h00}, ":00FFFF0101"},
    // A byte that continues the old address still opens a new record.
    '{ByModel,    '{1'b0, 16'h0011, 8'h66}, NoText}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  ihexw_in_t  in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ihexw_out_t out_word;

  // Encoder state mirrored for prediction.
  logic [7:0]  rec_bytes [RecBytes];
  int unsigned rec_len;
  logic [15:0] rec_base;
  logic [7:0]  rec_sum;
  logic [16:0] next_addr;
  bit          next_known;

  ihexw_out_t  record_text [$];
  ihexw_out_t  expected_text [$];
  int unsigned mismatches;
  int unsigned chars_seen;

  always #4 clk = ~clk;

  intel_hex_record_writer #(
    .MAX_RECORD_BYTES(RecBytes),
    .MEMORY_SIZE     (MemBytes)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  function automatic void put_char(logic [7:0] c);
    ihexw_out_t w;
    w.out_char = c;
    w.error    = 1'b0;
    w.last     = 1'b0;
    record_text.push_back(w);
  endfunction

  function automatic void put_hex(logic [7:0] v);
    put_char(HexDigits[(15 - v[7:4]) * 8 +: 8]);
    put_char(HexDigits[(15 - v[3:0]) * 8 +: 8]);
  endfunction

  // Writes one whole record; s holds the address bytes plus the data bytes.
  function automatic void put_record(logic [7:0] n, logic [15:0] a, logic [7:0] typ,
                                     logic [7:0] s);
    int i;
    put_char(ChColon);
    put_hex(n);
    put_hex(a[15:8]);
    put_hex(a[7:0]);
    put_hex(typ);
    for (i = 0; i < n; i++) begin
      put_hex(rec_bytes[i]);
    end
    s = s + n + typ;
    put_hex(8'h00 - s);
    put_char(ChCr);
    put_char(ChLf);
  endfunction

  function automatic void close_pending();
    if (rec_len != 0) begin
      put_record(8'(rec_len), rec_base, TypeData, rec_sum);
      rec_len = 0;
    end
  endfunction

  // Computes the text caused by one accepted word into record_text.
  function automatic void encode_word(ihexw_in_t w);
    logic [15:0] a;
    bit          follows;
    ihexw_out_t  tail;
    a = w.address;
    record_text.delete();
    if (w.cmd) begin
      close_pending();
      put_record(8'd0, a, TypeEof, a[15:8] + a[7:0]);
    end else if (a >= MemBytes) begin
      tail.out_char = ChNone;
      tail.error    = 1'b1;
      tail.last     = 1'b0;
      record_text.push_back(tail);
      next_addr  = {1'b0, a} + 17'd1;
      next_known = 1'b1;
    end else begin
      follows = next_known && (next_addr == {1'b0, a});
      if (!follows || rec_len == 0 || rec_len >= RecBytes) begin
        close_pending();
        rec_base = a;
        rec_sum  = a[15:8] + a[7:0];
        rec_len  = 0;
      end
      if (rec_len < RecBytes) begin
        rec_bytes[rec_len] = w.data_byte;
        rec_len++;
      end
      rec_sum    = rec_sum + w.data_byte;
      next_addr  = {1'b0, a} + 17'd1;
      next_known = 1'b1;
    end
    if (record_text.size() > 0) begin
      tail = record_text.pop_back();
      tail.last = 1'b1;
      record_text.push_back(tail);
    end
  endfunction

  // Queues the expected characters of an accepted word.
  function automatic void note_accepted(ihexw_in_t w, row_check_e check, logic [87:0] text);
    int i;
    encode_word(w);
    case (check)
      TypedError: begin
        expected_text.push_back('{ChNone, 1'b1, 1'b1});
      end
      TypedText: begin
        for (i = 10; i >= 0; i--) begin
          expected_text.push_back('{text[i * 8 +: 8], 1'b0, 1'b0});
        end
        expected_text.push_back('{ChCr, 1'b0, 1'b0});
        expected_text.push_back('{ChLf, 1'b0, 1'b1});
      end
      default: begin
        for (i = 0; i < record_text.size(); i++) begin
          expected_text.push_back(record_text[i]);
        end
      end
    endcase
  endfunction

  // Offers one word, with an optional random gap first, and waits until taken.
  task automatic send_word(ihexw_in_t w, row_check_e check, logic [87:0] text,
                           bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
    note_accepted(w, check, text);
  endtask

  function automatic void check_char(ihexw_out_t got);
    ihexw_out_t want;
    chars_seen++;
    if (expected_text.size() == 0) begin
      $error("unexpected output word: out_char %h error %b last %b",
             got.out_char, got.error, got.last);
      mismatches++;
    end else begin
      want = expected_text.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, got %h", want.out_char, got.out_char);
        mismatches++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %b, got %b", want.error, got.error);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        mismatches++;
      end
    end
  endfunction

  // Receiver: checks each taken word, stalls at random, holds off once for a
  // long stretch and runs without stalls for a while later on.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_char(out_word);
      end
      if (!hold_done && chars_seen >= 400) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (chars_seen >= 600 && chars_seen < 900) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 36);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Sender: directed plan, a pause until the output has drained, then
  // random runs of contiguous bytes mixed with finishes and stray addresses.
  initial begin
    ihexw_in_t   w;
    int unsigned issued;
    int unsigned pick;
    int unsigned run;
    int unsigned base;
    int unsigned j;
    int          k;
    rec_len    = 0;
    rec_base   = '0;
    rec_sum    = '0;
    next_addr  = '0;
    next_known = 1'b0;
    mismatches = 0;
    chars_seen = 0;
    issued     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 26; k++) begin
      send_word(Plan[k].word, Plan[k].check, Plan[k].text, 1'b1);
    end

    in_valid <= 1'b0;
    while (expected_text.size() != 0) begin
      @(posedge clk);
    end

    while (issued < RandomWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run  = $urandom_range(1, 20);
        base = $urandom_range(0, MemBytes - 1);
        for (j = 0; j < run && issued < RandomWords; j++) begin
          w.cmd       = 1'b0;
          w.address   = 16'(base + j);
          w.data_byte = 8'($urandom);
          send_word(w, ByModel, NoText, !(issued >= 120 && issued < 200));
          issued++;
        end
      end else begin
        w.cmd       = (pick < 78);
        w.data_byte = 8'($urandom);
        if (pick < 78) begin
          w.address = 16'($urandom);
        end else if (pick < 88) begin
          w.address = 16'($urandom_range(MemBytes, 65535));
        end else begin
          w.address = 16'($urandom_range(0, MemBytes - 1));
        end
        send_word(w, ByModel, NoText, !(issued >= 120 && issued < 200));
        issued++;
      end
    end

    in_valid <= 1'b0;
    while (expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
